// ===== hw/rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine: request modes,
// status codes, cell commands and the controller state type.
// ----------------------------------------------------------------------------
package ple_pkg;

    // Default sizing
    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the streams
    localparam int MODE_W  = 3;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int DOUT_W  = 32;
    localparam int FPOS_W  = 4;
    localparam int LEN_W   = 5;
    localparam int STAT_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Request modes (codes six and seven do nothing)
    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NONE   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    // Command broadcast to every cell
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;    // word update this cycle
        logic     find;  // search wave compares values, else positions
    } ple_ctl_t;

    // Controller states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_WAVE,
        FSM_DONE
    } fsm_t;

endpackage

// ===== hw/rtl/positional_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_top
// Bounded ordered list of data words held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each request transfer carries a mode (append, insert, read, remove, find,
// clear), a position and a value, and yields exactly one result transfer with
// the word read or removed, the found position, the new length and a status.
// Append, insert, clear, unused modes and errors on those load their result
// when the request is taken: every cell updates itself from its neighbours
// at once. Read, remove and find send a registered search wave down the
// CAPACITY cells, one cell per cycle; the next request transfer is taken only
// after the wave leaves the last cell and the result loads, and remove shifts
// the row when its result is loaded. A request is accepted whenever the block
// is idle and the result register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module positional_list_engine_top #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ple_pkg::S_TDATA_W-1:0]  s_tdata,   // mode[2:0], position[7:3], value[39:8]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ple_pkg::M_TDATA_W-1:0]  m_tdata    // data_out[31:0], found_position[35:32],
                                                      // length[40:36], status[42:41], zero pad
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    ple_pkg::ple_ctl_t           cell_ctl;
    logic [CNT_W-1:0]            cell_pos, cell_cnt;
    logic [DATA_WIDTH-1:0]       cell_key;
    logic [DATA_WIDTH-1:0]       words [CAPACITY];
    logic                        hits  [CAPACITY+1];
    logic [DATA_WIDTH-1:0]       wdata [CAPACITY+1];
    logic [IDX_W-1:0]            wfpos [CAPACITY+1];
    logic [ple_pkg::DOUT_W-1:0]  res_data;
    logic [ple_pkg::FPOS_W-1:0]  res_fpos;
    logic [ple_pkg::LEN_W-1:0]   res_len;
    logic [ple_pkg::STAT_W-1:0]  res_stat;

    // Controller
    ple_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .mode      (s_tdata[2:0]),
        .position  (s_tdata[7:3]),
        .value     (s_tdata[39:8]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .res_data  (res_data),
        .res_fpos  (res_fpos),
        .res_len   (res_len),
        .res_stat  (res_stat),
        .cell_ctl  (cell_ctl),
        .cell_pos  (cell_pos),
        .cell_cnt  (cell_cnt),
        .cell_key  (cell_key),
        .tail_hit  (hits[CAPACITY]),
        .tail_data (wdata[CAPACITY]),
        .tail_fpos (wfpos[CAPACITY])
    );

    // Wave enters the row empty
    assign hits[0]  = 1'b0;
    assign wdata[0] = '0;
    assign wfpos[0] = '0;

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = words[i];
        end else begin : g_mid_l
            assign left_w = words[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = words[i];
        end else begin : g_mid_r
            assign right_w = words[i+1];
        end
        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .IDX_W      (IDX_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctl        (cell_ctl),
            .pos        (cell_pos),
            .cnt        (cell_cnt),
            .key        (cell_key),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i]),
            .hit_in     (hits[i]),
            .data_in    (wdata[i]),
            .fpos_in    (wfpos[i]),
            .hit_out    (hits[i+1]),
            .data_out   (wdata[i+1]),
            .fpos_out   (wfpos[i+1])
        );
    end

    // Result packing
    assign m_tdata = {5'd0, res_stat, res_len, res_fpos, res_data};

endmodule

// ===== hw/rtl/ple_cell.sv =====
// ----------------------------------------------------------------------------
// ple_cell
// One list position: holds a word, shifts it to or from its neighbours on
// insert and remove, and forwards a registered search wave to the next cell.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = 5,
    parameter int IDX_W      = 4,
    parameter int INDEX      = 0
) (
    input  logic                  aclk,
    input  ple_pkg::ple_ctl_t     ctl,
    input  logic [CNT_W-1:0]      pos,
    input  logic [CNT_W-1:0]      cnt,
    input  logic [DATA_WIDTH-1:0] key,
    input  logic [DATA_WIDTH-1:0] left_word,
    input  logic [DATA_WIDTH-1:0] right_word,
    output logic [DATA_WIDTH-1:0] word,
    input  logic                  hit_in,
    input  logic [DATA_WIDTH-1:0] data_in,
    input  logic [IDX_W-1:0]      fpos_in,
    output logic                  hit_out,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [IDX_W-1:0]      fpos_out
);

    localparam logic [CNT_W-1:0] K     = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] K_IDX = IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] word_reg, word_next;
    logic                  hit_reg, hit_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [IDX_W-1:0]      fpos_reg, fpos_next;
    logic                  sel;

    // Word update
    always_comb begin
        word_next = word_reg;
        unique case (ctl.op)
            ple_pkg::CELL_APPEND: begin
                if (K == cnt) word_next = key;
            end
            ple_pkg::CELL_INSERT: begin
                if (K > pos)       word_next = left_word;
                else if (K == pos) word_next = key;
            end
            ple_pkg::CELL_REMOVE: begin
                if (K >= pos) word_next = right_word;
            end
            default: word_next = word_reg;
        endcase
    end

    // Search wave: first selected cell claims the wave
    always_comb begin
        if (ctl.find) sel = (K < cnt) && (word_reg == key);
        else          sel = (K == pos);
        if (!hit_in && sel) begin
            hit_next  = 1'b1;
            data_next = word_reg;
            fpos_next = K_IDX;
        end else begin
            hit_next  = hit_in;
            data_next = data_in;
            fpos_next = fpos_in;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        hit_reg  <= hit_next;
        data_reg <= data_next;
        fpos_reg <= fpos_next;
    end

    assign word     = word_reg;
    assign hit_out  = hit_reg;
    assign data_out = data_reg;
    assign fpos_out = fpos_reg;

endmodule

// ===== hw/rtl/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl
// Request decoder, length counter and result register. Drives the cell row
// and waits for the search wave on read, remove and find.
// ----------------------------------------------------------------------------
module ple_ctrl #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(CAPACITY + 1),
    parameter int IDX_W      = $clog2(CAPACITY)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ple_pkg::MODE_W-1:0]    mode,
    input  logic [ple_pkg::POS_W-1:0]     position,
    input  logic [ple_pkg::VALUE_W-1:0]   value,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ple_pkg::DOUT_W-1:0]    res_data,
    output logic [ple_pkg::FPOS_W-1:0]    res_fpos,
    output logic [ple_pkg::LEN_W-1:0]     res_len,
    output logic [ple_pkg::STAT_W-1:0]    res_stat,
    output ple_pkg::ple_ctl_t             cell_ctl,
    output logic [CNT_W-1:0]              cell_pos,
    output logic [CNT_W-1:0]              cell_cnt,
    output logic [DATA_WIDTH-1:0]         cell_key,
    input  logic                          tail_hit,
    input  logic [DATA_WIDTH-1:0]         tail_data,
    input  logic [IDX_W-1:0]              tail_fpos
);

    localparam int CMP_W = (CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] WAVE_END = IDX_W'(CAPACITY - 1);

    ple_pkg::fsm_t state_reg, state_next;
    logic [IDX_W-1:0]            wcnt_reg, wcnt_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [ple_pkg::MODE_W-1:0]  req_mode_reg, req_mode_next;
    logic [CNT_W-1:0]            req_pos_reg, req_pos_next;
    logic [DATA_WIDTH-1:0]       req_key_reg, req_key_next;
    logic [ple_pkg::STAT_W-1:0]  req_stat_reg, req_stat_next;
    logic                        m_valid_reg, m_valid_next;
    logic [ple_pkg::DOUT_W-1:0]  data_reg, data_next;
    logic [ple_pkg::FPOS_W-1:0]  fpos_reg, fpos_next;
    logic [ple_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [ple_pkg::STAT_W-1:0]  stat_reg, stat_next;

    logic                  out_free, accept, load, full, wave_mode, req_find;
    logic [CMP_W-1:0]      pos_ext, cnt_ext;
    logic [DATA_WIDTH-1:0] key_in;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ple_pkg::FSM_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign full      = (count_reg == FULL_CNT);
    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign key_in    = DATA_WIDTH'(value);
    assign req_find  = (req_mode_reg == ple_pkg::MODE_FIND);
    assign wave_mode = (mode == ple_pkg::MODE_READ) || (mode == ple_pkg::MODE_REMOVE)
                    || (mode == ple_pkg::MODE_FIND);

    // Buses to the cell row: live request while idle, held request otherwise
    assign cell_pos = (state_reg == ple_pkg::FSM_IDLE) ? CNT_W'(position) : req_pos_reg;
    assign cell_key = (state_reg == ple_pkg::FSM_IDLE) ? key_in : req_key_reg;
    assign cell_cnt = count_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        wcnt_next  = wcnt_reg;
        unique case (state_reg)
            ple_pkg::FSM_IDLE: begin
                if (accept && wave_mode) begin
                    state_next = ple_pkg::FSM_WAVE;
                    wcnt_next  = '0;
                end
            end
            ple_pkg::FSM_WAVE: begin
                wcnt_next = wcnt_reg + IDX_W'(1);
                if (wcnt_reg == WAVE_END) state_next = ple_pkg::FSM_DONE;
            end
            ple_pkg::FSM_DONE: begin
                if (out_free) state_next = ple_pkg::FSM_IDLE;
            end
            default: state_next = ple_pkg::FSM_IDLE;
        endcase
    end

    // Decode, list updates and result
    always_comb begin
        cell_ctl.op   = ple_pkg::CELL_HOLD;
        cell_ctl.find = req_find;
        load          = 1'b0;
        count_next    = count_reg;
        data_next     = data_reg;
        fpos_next     = fpos_reg;
        stat_next     = stat_reg;
        req_mode_next = req_mode_reg;
        req_pos_next  = req_pos_reg;
        req_key_next  = req_key_reg;
        req_stat_next = req_stat_reg;
        // result fields default to a plain ok
        if (accept) begin
            req_mode_next = mode;
            req_pos_next  = CNT_W'(position);
            req_key_next  = key_in;
            if (count_reg == '0)       req_stat_next = ple_pkg::STAT_NONE;
            else if (pos_ext >= cnt_ext) req_stat_next = ple_pkg::STAT_BADPOS;
            else                       req_stat_next = ple_pkg::STAT_OK;
            data_next = '0;
            fpos_next = '0;
            stat_next = ple_pkg::STAT_OK;
            unique case (mode)
                ple_pkg::MODE_APPEND: begin
                    load = 1'b1;
                    if (full) begin
                        stat_next = ple_pkg::STAT_FULL;
                    end else begin
                        cell_ctl.op = ple_pkg::CELL_APPEND;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                ple_pkg::MODE_INSERT: begin
                    load = 1'b1;
                    if (pos_ext > cnt_ext) begin
                        stat_next = ple_pkg::STAT_BADPOS;
                    end else if (full) begin
                        stat_next = ple_pkg::STAT_FULL;
                    end else begin
                        cell_ctl.op = ple_pkg::CELL_INSERT;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                ple_pkg::MODE_READ, ple_pkg::MODE_REMOVE, ple_pkg::MODE_FIND: begin
                    load = 1'b0;
                end
                ple_pkg::MODE_CLEAR: begin
                    load       = 1'b1;
                    count_next = '0;
                end
                default: load = 1'b1;
            endcase
        end else if (state_reg == ple_pkg::FSM_DONE && out_free) begin
            load      = 1'b1;
            data_next = '0;
            fpos_next = '0;
            if (req_find) begin
                stat_next = tail_hit ? ple_pkg::STAT_OK : ple_pkg::STAT_NONE;
                if (tail_hit) fpos_next = ple_pkg::FPOS_W'(tail_fpos);
            end else begin
                stat_next = req_stat_reg;
                if (req_stat_reg == ple_pkg::STAT_OK) begin
                    data_next = ple_pkg::DOUT_W'(tail_data);
                    if (req_mode_reg == ple_pkg::MODE_REMOVE) begin
                        cell_ctl.op = ple_pkg::CELL_REMOVE;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
            end
        end
        len_next = load ? ple_pkg::LEN_W'(count_next) : len_reg;
        if (load)          m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
        else               m_valid_next = m_valid_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ple_pkg::FSM_IDLE;
            wcnt_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wcnt_reg    <= wcnt_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_mode_reg <= req_mode_next;
        req_pos_reg  <= req_pos_next;
        req_key_reg  <= req_key_next;
        req_stat_reg <= req_stat_next;
        data_reg     <= data_next;
        fpos_reg     <= fpos_next;
        len_reg      <= len_next;
        stat_reg     <= stat_next;
    end

    assign m_tvalid = m_valid_reg;
    assign res_data = data_reg;
    assign res_fpos = fpos_reg;
    assign res_len  = len_reg;
    assign res_stat = stat_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("list length beyond capacity");

    a_wave_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ple_pkg::FSM_WAVE) |=> (count_reg == $past(count_reg)))
        else $error("length changed during search wave");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && stat_reg == ple_pkg::STAT_FULL) |-> (len_reg == ple_pkg::LEN_W'(CAPACITY)))
        else $error("full status with list not full");

    a_accept_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_valid_reg || state_reg != ple_pkg::FSM_IDLE))
        else $error("accepted request produced neither result nor wave");

endmodule
